// ===== hdl/keypad_combination_lock_top_macros.svh =====
// Assertion macros used by the keypad lock RTL (included by kcl_ctrl).
`ifndef KEYPAD_COMBINATION_LOCK_TOP_MACROS_SVH
`define KEYPAD_COMBINATION_LOCK_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define KCL_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad lock assertion failed");
// Next-cycle implication
`define KCL_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad lock assertion failed");
`else
`define KCL_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define KCL_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/kcl_pkg.sv =====
// Shared codes and types for the keypad combination lock.
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int KCL_MAX_DIGITS = 8;
  localparam logic [3:0] DEFAULT_ATTEMPTS = 4'd3;

  // Key codes
  localparam logic [4:0] KEY_DIGIT_MAX = 5'd9;
  localparam logic [4:0] KEY_A     = 5'd10;
  localparam logic [4:0] KEY_B     = 5'd11;
  localparam logic [4:0] KEY_C     = 5'd12;
  localparam logic [4:0] KEY_D     = 5'd13;
  localparam logic [4:0] KEY_STAR  = 5'd14;
  localparam logic [4:0] KEY_HASH  = 5'd15;
  localparam logic [4:0] KEY_OPEN  = 5'd16;
  localparam logic [4:0] KEY_CLOSE = 5'd17;

  // Lock modes
  localparam logic [2:0] MODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_SETUP    = 3'd1;
  localparam logic [2:0] MODE_VERIFY   = 3'd2;
  localparam logic [2:0] MODE_UNLOCKED = 3'd3;
  localparam logic [2:0] MODE_CHANGE   = 3'd4;
  localparam logic [2:0] MODE_LOCKOUT  = 3'd5;

  // Event codes
  localparam logic [3:0] EV_IGNORED = 4'd0;
  localparam logic [3:0] EV_TAKEN   = 4'd1;
  localparam logic [3:0] EV_DROPPED = 4'd2;
  localparam logic [3:0] EV_CLEARED = 4'd3;
  localparam logic [3:0] EV_STORED  = 4'd4;
  localparam logic [3:0] EV_CORRECT = 4'd5;
  localparam logic [3:0] EV_WRONG   = 4'd6;
  localparam logic [3:0] EV_LOCKOUT = 4'd7;
  localparam logic [3:0] EV_OPENED  = 4'd8;
  localparam logic [3:0] EV_CLOSED  = 4'd9;
  localparam logic [3:0] EV_STARTED = 4'd10;

  // Commands from the sequencer to the digit store
  typedef struct packed {
    logic wr_entry;
    logic rd;
    logic wr_stored;
  } mem_cmd_t;

endpackage

// ===== hdl/kcl_digit_store.sv =====
// Entry and password digit memories with the shared digit compare.
`timescale 1ns / 1ps

module kcl_digit_store #(
  parameter int MAX_DIGITS = kcl_pkg::KCL_MAX_DIGITS
) (
  input  logic                                      clk,
  input  kcl_pkg::mem_cmd_t                         cmd,
  input  logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] wr_idx,
  input  logic [3:0]                                wr_digit,
  input  logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] sweep_idx,
  output logic                                      digit_eq
);
  import kcl_pkg::*;

  logic [3:0] entry_mem  [MAX_DIGITS];
  logic [3:0] stored_mem [MAX_DIGITS];
  logic [3:0] entry_q;
  logic [3:0] stored_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_entry) begin
      entry_mem[wr_idx] <= wr_digit;
    end
    if (cmd.rd) begin
      entry_q  <= entry_mem[sweep_idx];
      stored_q <= stored_mem[sweep_idx];
    end
    // copy the digit fetched in the previous cycle into the password
    if (cmd.wr_stored) begin
      stored_mem[sweep_idx] <= entry_q;
    end
  end

  assign digit_eq = (entry_q == stored_q);

endmodule

// ===== hdl/kcl_ctrl.sv =====
// Sequencer and lock state for the keypad combination lock.
`timescale 1ns / 1ps
`include "keypad_combination_lock_top_macros.svh"

module kcl_ctrl #(
  parameter int MAX_DIGITS = kcl_pkg::KCL_MAX_DIGITS
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [4:0]                                key,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [2:0]                                mode,
  output logic                                      door_enable,
  output logic                                      echo_valid,
  output logic [3:0]                                echo_digit,
  output logic                                      echo_masked,
  output logic [3:0]                                attempts_left,
  output logic [3:0]                                event_res,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [3:0]                                cfg_data,
  output kcl_pkg::mem_cmd_t                         mem_cmd,
  output logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] wr_idx,
  output logic [3:0]                                wr_digit,
  output logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] sweep_idx,
  input  logic                                      digit_eq
);
  import kcl_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_RD   = 5'b00100,
    S_CHK  = 5'b01000,
    S_DONE = 5'b10000
  } seq_state_t;

  seq_state_t       seq_state;
  logic [4:0]       key_q;
  logic [2:0]       lock_mode;
  logic             door_allowed;
  logic             mask_echo;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] stored_length;
  logic             stored_valid;
  logic [3:0]       tries_left;
  logic [3:0]       max_attempts;
  logic [CNT_W-1:0] idx;
  logic             op_copy;
  logic [3:0]       ev;
  logic             ev_valid;
  logic [3:0]       ev_digit;
  logic             ev_mask;

  logic             entry_mode;
  logic             is_digit;
  logic             in_exec;
  logic             in_chk;
  logic [CNT_W-1:0] idx_inc;
  logic             last;
  logic             len_eq;
  logic             c_ok;
  logic             h_ok;
  logic             take_digit;
  logic             start_sweep;
  logic             store_fin;
  logic             correct_fin;
  logic             wrong_fin;
  logic [3:0]       tries_dec;
  logic             load_out;

  always_comb begin
    entry_mode  = (lock_mode == MODE_SETUP) || (lock_mode == MODE_VERIFY) ||
                  (lock_mode == MODE_CHANGE);
    is_digit    = (key_q <= KEY_DIGIT_MAX);
    in_exec     = (seq_state == S_EXEC);
    in_chk      = (seq_state == S_CHK);
    idx_inc     = idx + CNT_W'(1);
    last        = (idx_inc == entry_count);
    len_eq      = (entry_count == stored_length);
    c_ok        = (key_q == KEY_C) &&
                  ((lock_mode == MODE_SETUP) || (lock_mode == MODE_CHANGE));
    h_ok        = (key_q == KEY_HASH) && (lock_mode == MODE_VERIFY);
    take_digit  = in_exec && is_digit && entry_mode && (entry_count < CNT_MAX);
    start_sweep = in_exec && ((c_ok && (entry_count != '0)) ||
                              (h_ok && len_eq && (entry_count != '0)));
    store_fin   = (in_exec && c_ok && (entry_count == '0)) ||
                  (in_chk && op_copy && last);
    correct_fin = (in_exec && h_ok && len_eq && (entry_count == '0)) ||
                  (in_chk && !op_copy && digit_eq && last);
    wrong_fin   = (in_exec && h_ok && !len_eq) ||
                  (in_chk && !op_copy && !digit_eq);
    tries_dec   = (tries_left == 4'd0) ? 4'd0 : tries_left - 4'd1;
    load_out    = (seq_state == S_DONE) && (!out_valid || !out_stall);

    mem_cmd.wr_entry  = take_digit;
    mem_cmd.rd        = (seq_state == S_RD);
    mem_cmd.wr_stored = in_chk && op_copy;
  end

  assign wr_idx    = entry_count[IDX_W-1:0];
  assign wr_digit  = key_q[3:0];
  assign sweep_idx = idx[IDX_W-1:0];
  assign in_stall  = (seq_state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state     <= S_IDLE;
      lock_mode     <= MODE_IDLE;
      door_allowed  <= 1'b0;
      mask_echo     <= 1'b0;
      entry_count   <= '0;
      stored_length <= '0;
      stored_valid  <= 1'b0;
      tries_left    <= DEFAULT_ATTEMPTS;
      max_attempts  <= DEFAULT_ATTEMPTS;
      out_valid     <= 1'b0;
      op_copy       <= 1'b0;
      idx           <= '0;
    end else begin
      if (cfg_valid) begin
        max_attempts <= cfg_data;
      end

      // output register: load a finished item, drop one that was taken
      if (load_out) begin
        out_valid     <= 1'b1;
        mode          <= lock_mode;
        door_enable   <= door_allowed;
        echo_valid    <= ev_valid;
        echo_digit    <= ev_digit;
        echo_masked   <= ev_mask;
        attempts_left <= tries_left;
        event_res     <= ev;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (seq_state)
        S_IDLE: begin
          if (in_valid) begin
            key_q     <= key;
            ev        <= EV_IGNORED;
            ev_valid  <= 1'b0;
            ev_digit  <= 4'd0;
            ev_mask   <= 1'b0;
            seq_state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (start_sweep) begin
            idx       <= '0;
            op_copy   <= c_ok;
            seq_state <= S_RD;
          end else begin
            seq_state <= S_DONE;
            if (is_digit) begin
              if (entry_mode) begin
                if (take_digit) begin
                  entry_count <= entry_count + CNT_W'(1);
                  ev          <= EV_TAKEN;
                  ev_valid    <= 1'b1;
                  ev_digit    <= key_q[3:0];
                  ev_mask     <= mask_echo;
                end else begin
                  ev <= EV_DROPPED;
                end
              end
            end else begin
              case (key_q)
                KEY_A: begin
                  if ((lock_mode == MODE_UNLOCKED) || (lock_mode == MODE_CHANGE)) begin
                    lock_mode   <= MODE_CHANGE;
                    mask_echo   <= 1'b0;
                    entry_count <= '0;
                    ev          <= EV_STARTED;
                  end
                end
                KEY_B: begin
                  if ((lock_mode == MODE_UNLOCKED) || (lock_mode == MODE_CHANGE)) begin
                    door_allowed <= 1'b0;
                    entry_count  <= '0;
                    lock_mode    <= MODE_IDLE;
                    ev           <= EV_CLOSED;
                  end
                end
                KEY_D: begin
                  if (entry_mode) begin
                    entry_count <= '0;
                    ev          <= EV_CLEARED;
                  end
                end
                KEY_STAR: begin
                  if (lock_mode == MODE_IDLE) begin
                    entry_count <= '0;
                    lock_mode   <= stored_valid ? MODE_VERIFY : MODE_SETUP;
                    mask_echo   <= stored_valid;
                    ev          <= EV_STARTED;
                  end
                end
                KEY_OPEN: begin
                  door_allowed <= 1'b1;
                  ev           <= EV_OPENED;
                end
                KEY_CLOSE: begin
                  door_allowed <= 1'b0;
                  entry_count  <= '0;
                  lock_mode    <= MODE_IDLE;
                  ev           <= EV_CLOSED;
                end
                default: begin
                  // C and hash finish below; other codes are ignored
                end
              endcase
            end
          end
        end
        S_RD: begin
          seq_state <= S_CHK;
        end
        S_CHK: begin
          if (store_fin || correct_fin || wrong_fin) begin
            seq_state <= S_DONE;
          end else begin
            idx       <= idx_inc;
            seq_state <= S_RD;
          end
        end
        S_DONE: begin
          if (load_out) begin
            seq_state <= S_IDLE;
          end
        end
        default: begin
          seq_state <= S_IDLE;
        end
      endcase

      if (store_fin) begin
        stored_length <= entry_count;
        stored_valid  <= 1'b1;
        tries_left    <= max_attempts;
        entry_count   <= '0;
        ev            <= EV_STORED;
        if (lock_mode == MODE_SETUP) begin
          lock_mode <= MODE_VERIFY;
          mask_echo <= 1'b1;
        end else begin
          lock_mode <= MODE_IDLE;
        end
      end

      if (correct_fin) begin
        lock_mode    <= MODE_UNLOCKED;
        door_allowed <= 1'b1;
        ev           <= EV_CORRECT;
      end

      if (wrong_fin) begin
        door_allowed <= 1'b0;
        entry_count  <= '0;
        tries_left   <= tries_dec;
        if (tries_dec == 4'd0) begin
          lock_mode <= MODE_LOCKOUT;
          ev        <= EV_LOCKOUT;
        end else begin
          ev <= EV_WRONG;
        end
      end
    end
  end

  `KCL_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, entry_count <= CNT_MAX)
  `KCL_ASSERT_IMPLY(a_sweep_in_range, clk, rst, mem_cmd.rd || in_chk, idx < entry_count)
  `KCL_ASSERT_IMPLY(a_lockout_empty, clk, rst, lock_mode == MODE_LOCKOUT, tries_left == 4'd0)
  `KCL_ASSERT_IMPLY(a_result_from_done, clk, rst, $rose(out_valid), $past(seq_state) == S_DONE)
  `KCL_ASSERT_NEXT(a_accept_starts, clk, rst, (seq_state == S_IDLE) && in_valid, seq_state == S_EXEC)

endmodule

// ===== hdl/keypad_combination_lock_top.sv =====
// Keypad combination lock top level: one key press in, one status item out.
// Each key is latched, executed and finished before its status item is
// registered; a hash or C key over an n-digit entry first sweeps the digits,
// reading and then comparing or copying each one. No new key is taken until
// the last one's item is loaded, which out_stall can hold. Synchronous reset
// clears mode to idle, attempts to 3 and the password flag; digits are not.
`timescale 1ns / 1ps

module keypad_combination_lock_top #(
  parameter int MAX_DIGITS = kcl_pkg::KCL_MAX_DIGITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] mode,
  output logic       door_enable,
  output logic       echo_valid,
  output logic [3:0] echo_digit,
  output logic       echo_masked,
  output logic [3:0] attempts_left,
  output logic [3:0] event_res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);
  import kcl_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  mem_cmd_t         mem_cmd;
  logic [IDX_W-1:0] wr_idx;
  logic [3:0]       wr_digit;
  logic [IDX_W-1:0] sweep_idx;
  logic             digit_eq;

  kcl_ctrl #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .key           (key),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .mode          (mode),
    .door_enable   (door_enable),
    .echo_valid    (echo_valid),
    .echo_digit    (echo_digit),
    .echo_masked   (echo_masked),
    .attempts_left (attempts_left),
    .event_res     (event_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mem_cmd       (mem_cmd),
    .wr_idx        (wr_idx),
    .wr_digit      (wr_digit),
    .sweep_idx     (sweep_idx),
    .digit_eq      (digit_eq)
  );

  kcl_digit_store #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_digit_store (
    .clk       (clk),
    .cmd       (mem_cmd),
    .wr_idx    (wr_idx),
    .wr_digit  (wr_digit),
    .sweep_idx (sweep_idx),
    .digit_eq  (digit_eq)
  );

endmodule
